/* rtl/mm4_pkg.sv */
// Shared types and constants for the fixed-point matrix multiplier.
// Used by mm4_cell, mm4_sat and matrix_multiply_4x4; depends on nothing.
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int PROD_W    = 64;
  localparam int FRAC_BITS = 16;

  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_e;

  // Element write request broadcast to every cell.
  typedef struct packed {
    logic                    left;
    logic                    right;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } wr_t;

endpackage

/* rtl/mm4_cell.sv */
// One cell of the multiply-accumulate chain: holds one column of the left matrix and one row of the right matrix.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_cell #(
  parameter int MATRIX_DIM = 4,
  parameter int CELL_IDX   = 0,
  localparam int XW = $clog2(MATRIX_DIM),
  localparam int KW = $clog2(MATRIX_DIM * MATRIX_DIM),
  localparam int SW = mm4_pkg::PROD_W + $clog2(MATRIX_DIM)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  mm4_pkg::wr_t         wr_i,
  input  logic                 valid_i,
  input  logic [XW-1:0]        x_i,
  input  logic [XW-1:0]        y_i,
  input  logic [KW-1:0]        k_i,
  input  logic signed [SW-1:0] sum_i,
  output logic                 valid_o,
  output logic [XW-1:0]        x_o,
  output logic [XW-1:0]        y_o,
  output logic [KW-1:0]        k_o,
  output logic signed [SW-1:0] sum_o
);

  // left_q[j] is left element j + CELL_IDX*D, right_q[j] is right element CELL_IDX + j*D.
  logic signed [mm4_pkg::VAL_W-1:0]  left_q  [MATRIX_DIM];
  logic signed [mm4_pkg::VAL_W-1:0]  right_q [MATRIX_DIM];

  logic                              v1_q, v2_q;
  logic [XW-1:0]                     x1_q, y1_q, x2_q, y2_q;
  logic [KW-1:0]                     k1_q, k2_q;
  logic signed [SW-1:0]              sum1_q, sum2_q;
  logic signed [mm4_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [SW-1:0]              sum2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        left_q[j]  <= '0;
        right_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < MATRIX_DIM; j++) begin
        if (wr_i.left && (int'(wr_i.idx) == j + CELL_IDX * MATRIX_DIM)) begin
          left_q[j] <= wr_i.value;
        end
        if (wr_i.right && (int'(wr_i.idx) == CELL_IDX + j * MATRIX_DIM)) begin
          right_q[j] <= wr_i.value;
        end
      end
    end
  end

  assign prod_d = left_q[x_i] * right_q[y_i];
  assign sum2_d = sum1_q + {{(SW - mm4_pkg::PROD_W){prod_q[mm4_pkg::PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_q   <= x_i;
      y1_q   <= y_i;
      k1_q   <= k_i;
      sum1_q <= sum_i;
      prod_q <= prod_d;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      k2_q   <= k1_q;
      sum2_q <= sum2_d;
    end
  end

  assign valid_o = v2_q;
  assign x_o     = x2_q;
  assign y_o     = y2_q;
  assign k_o     = k2_q;
  assign sum_o   = sum2_q;

endmodule

/* rtl/mm4_sat.sv */
// Output stage: drops the fraction bits, saturates to 32 bits and holds the result.
// Depends on mm4_pkg.
`timescale 1ns / 1ps

module mm4_sat #(
  parameter int MATRIX_DIM = 4,
  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM,
  localparam int KW = $clog2(ELEMS),
  localparam int SW = mm4_pkg::PROD_W + $clog2(MATRIX_DIM)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [KW-1:0]                      k_i,
  input  logic signed [SW-1:0]               sum_i,
  output logic                               adv_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [mm4_pkg::IDX_W-1:0]          m_index_o,
  output logic signed [mm4_pkg::VAL_W-1:0]   m_value_o,
  output logic                               m_last_o,
  output logic                               m_ovf_o
);

  localparam int HW = SW - mm4_pkg::FRAC_BITS;

  logic [HW-1:0]                     whole;
  logic                              ovf_d;
  logic signed [mm4_pkg::VAL_W-1:0]  value_d;
  logic [KW+mm4_pkg::IDX_W-1:0]      k_ext;

  logic                              valid_q;
  logic [mm4_pkg::IDX_W-1:0]         index_q;
  logic signed [mm4_pkg::VAL_W-1:0]  value_q;
  logic                              last_q, ovf_q;

  // Arithmetic shift is a floor; the value fits when all bits above bit 31 match it.
  assign whole = sum_i[SW-1:mm4_pkg::FRAC_BITS];
  assign ovf_d = !((&whole[HW-1:mm4_pkg::VAL_W-1]) || !(|whole[HW-1:mm4_pkg::VAL_W-1]));

  always_comb begin
    if (!ovf_d) begin
      value_d = whole[mm4_pkg::VAL_W-1:0];
    end else if (whole[HW-1]) begin
      value_d = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};
    end else begin
      value_d = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
    end
  end

  assign k_ext = (KW + mm4_pkg::IDX_W)'(k_i);
  assign adv_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      index_q <= k_ext[mm4_pkg::IDX_W-1:0];
      value_q <= value_d;
      last_q  <= (k_i == KW'(ELEMS - 1));
      ovf_q   <= ovf_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_index_o = index_q;
  assign m_value_o = value_q;
  assign m_last_o  = last_q;
  assign m_ovf_o   = ovf_q;

endmodule

/* rtl/matrix_multiply_4x4.sv */
// Top level of the fixed-point matrix multiplier: request decode, issue control
// and the cell chain. Depends on mm4_pkg, mm4_cell and mm4_sat.
//
// Multiplies two MATRIX_DIM x MATRIX_DIM matrices of signed Q16.16 values kept
// column-major. A load request (tuser 0 left, 1 right) writes one element;
// loads to an index past the matrix and tuser 3 are dropped. A compute request
// (tuser 2) streams all MATRIX_DIM^2 products in index order, one per cycle
// when the sink keeps up, the last one flagged with tlast and tuser set where
// the element saturated. Each product passes through the chain of MATRIX_DIM
// multiply-accumulate cells at two stages each and then the output register;
// a compute request therefore holds off the input, and new requests are taken
// again once the last product sits in the output register. Both matrices are
// zero after reset.
`timescale 1ns / 1ps

module matrix_multiply_4x4 #(
  parameter int MATRIX_DIM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // elem_index[3:0], elem_value[35:4], zero pad
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_index[3:0], out_value[35:4], zero pad
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // out_overflow
);

  localparam int ELEMS = MATRIX_DIM * MATRIX_DIM;
  localparam int XW    = $clog2(MATRIX_DIM);
  localparam int KW    = $clog2(ELEMS);
  localparam int SW    = mm4_pkg::PROD_W + $clog2(MATRIX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e                            state_q, state_d;
  logic [XW-1:0]                     x_q, x_d, y_q, y_d;
  logic [KW-1:0]                     k_q, k_d;

  logic                              in_fire, adv;
  mm4_pkg::op_e                      op;
  logic [mm4_pkg::IDX_W-1:0]         in_idx;
  logic signed [mm4_pkg::VAL_W-1:0]  in_val;
  logic                              idx_ok;
  mm4_pkg::wr_t                      wr;

  logic                              chain_v [MATRIX_DIM+1];
  logic [XW-1:0]                     chain_x [MATRIX_DIM+1];
  logic [XW-1:0]                     chain_y [MATRIX_DIM+1];
  logic [KW-1:0]                     chain_k [MATRIX_DIM+1];
  logic signed [SW-1:0]              chain_s [MATRIX_DIM+1];

  logic [mm4_pkg::IDX_W-1:0]         out_index;
  logic signed [mm4_pkg::VAL_W-1:0]  out_value;
  logic                              end_last;

  assign op      = mm4_pkg::op_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[3:0];
  assign in_val  = s_axis_tdata[35:4];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign idx_ok  = (int'(in_idx) < ELEMS);

  always_comb begin
    wr       = '0;
    wr.idx   = in_idx;
    wr.value = in_val;
    wr.left  = in_fire && (op == mm4_pkg::OP_LOAD_LEFT) && idx_ok;
    wr.right = in_fire && (op == mm4_pkg::OP_LOAD_RIGHT) && idx_ok;
  end

  assign end_last = chain_v[MATRIX_DIM] && (chain_k[MATRIX_DIM] == KW'(ELEMS - 1));

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    k_d     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (op == mm4_pkg::OP_COMPUTE)) begin
          state_d = ST_ISSUE;
          x_d     = '0;
          y_d     = '0;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          k_d = k_q + 1'b1;
          if (x_q == XW'(MATRIX_DIM - 1)) begin
            x_d = '0;
            y_d = y_q + 1'b1;
          end else begin
            x_d = x_q + 1'b1;
          end
          if (k_q == KW'(ELEMS - 1)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // The final product has reached the output register once it leaves the chain.
        if (adv && end_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
      k_q     <= k_d;
    end
  end

  assign chain_v[0] = (state_q == ST_ISSUE);
  assign chain_x[0] = x_q;
  assign chain_y[0] = y_q;
  assign chain_k[0] = k_q;
  assign chain_s[0] = '0;

  for (genvar e = 0; e < MATRIX_DIM; e++) begin : g_cell
    mm4_cell #(
      .MATRIX_DIM (MATRIX_DIM),
      .CELL_IDX   (e)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .wr_i    (wr),
      .valid_i (chain_v[e]),
      .x_i     (chain_x[e]),
      .y_i     (chain_y[e]),
      .k_i     (chain_k[e]),
      .sum_i   (chain_s[e]),
      .valid_o (chain_v[e+1]),
      .x_o     (chain_x[e+1]),
      .y_o     (chain_y[e+1]),
      .k_o     (chain_k[e+1]),
      .sum_o   (chain_s[e+1])
    );
  end

  mm4_sat #(
    .MATRIX_DIM (MATRIX_DIM)
  ) u_sat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (chain_v[MATRIX_DIM]),
    .k_i       (chain_k[MATRIX_DIM]),
    .sum_i     (chain_s[MATRIX_DIM]),
    .adv_o     (adv),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_index_o (out_index),
    .m_value_o (out_value),
    .m_last_o  (m_axis_tlast),
    .m_ovf_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, out_value, out_index};

`ifndef ASSERT_OFF
  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !chain_v[MATRIX_DIM])
    else $error("product still in the chain while idle");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op == mm4_pkg::OP_COMPUTE)) |=> (state_q == ST_ISSUE) && (k_q == '0))
    else $error("compute request did not start issue at element zero");

  a_last_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_last |-> (state_q == ST_DRAIN))
    else $error("final product left the chain outside of drain");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[3:0] == 4'(ELEMS - 1)))
    else $error("last product carries the wrong index");
`endif

endmodule

/* test/matrix_multiply_4x4_tb.sv */
// Self-checking testbench for matrix_multiply_4x4: streams element loads and compute
// requests, predicts every saturated Q16.16 product and checks the output stream.
// Depends on mm4_pkg and the matrix_multiply_4x4 RTL.
`timescale 1ns / 1ps

module matrix_multiply_4x4_tb;

  localparam int DIM       = 4;
  localparam int ELEMS     = DIM * DIM;
  localparam int VAL_W     = mm4_pkg::VAL_W;
  localparam int IDX_W     = mm4_pkg::IDX_W;
  localparam int FRAC_BITS = mm4_pkg::FRAC_BITS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [67:0] SUM_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SUM_MIN = -68'sd2147483648;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_ONE = 32'h0001_0000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             ovf;
  } product_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // elem_index[3:0], elem_value[35:4], zero pad
  logic [1:0]  s_axis_tuser = '0;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_index[3:0], out_value[35:4], zero pad
  logic        m_axis_tlast;
  logic        m_axis_tuser;        // out_overflow

  logic signed [VAL_W-1:0] lhs_mat [ELEMS];
  logic signed [VAL_W-1:0] rhs_mat [ELEMS];
  product_t    expected_products [$];
  int unsigned mismatches = 0;
  bit          src_idle_en = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned sink_hold = 0;

  matrix_multiply_4x4 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Exact sum of the four Q32.32 products, floored back to Q16.16 and saturated.
  function automatic logic [VAL_W-1:0] dot_product(int x, int y, output logic ovf);
    logic signed [67:0] acc;
    logic signed [67:0] scaled;
    acc = '0;
    for (int e = 0; e < DIM; e++) begin
      acc = acc + (longint'(lhs_mat[x + e * DIM]) * longint'(rhs_mat[e + y * DIM]));
    end
    scaled = acc >>> FRAC_BITS;
    ovf = 1'b1;
    if (scaled > SUM_MAX) return VAL_MAX;
    if (scaled < SUM_MIN) return VAL_MIN;
    ovf = 1'b0;
    return scaled[VAL_W-1:0];
  endfunction

  function automatic void apply_request(logic [1:0] op, logic [IDX_W-1:0] idx,
                                        logic [VAL_W-1:0] val);
    product_t p;
    case (op)
      mm4_pkg::OP_LOAD_LEFT:  lhs_mat[idx] = val;
      mm4_pkg::OP_LOAD_RIGHT: rhs_mat[idx] = val;
      mm4_pkg::OP_COMPUTE: begin
        for (int y = 0; y < DIM; y++) begin
          for (int x = 0; x < DIM; x++) begin
            p.idx   = IDX_W'(x + y * DIM);
            p.value = dot_product(x, y, p.ovf);
            p.last  = (x + y * DIM == ELEMS - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val);
    int unsigned gap;
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(op, idx, val);
  endtask

  // Sink side: long hold-offs take priority over the random stall bursts.
  initial begin : sink_drive
    int unsigned gap = 0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
      end
    end
  end

  function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endfunction

  always @(posedge clk_i) begin : check_products
    product_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_products.size() == 0) begin
        flag_mismatch("unexpected product", '0, m_axis_tdata[35:4]);
      end else begin
        want = expected_products.pop_front();
        if (m_axis_tdata[3:0] !== want.idx)
          flag_mismatch("out_index", want.idx, m_axis_tdata[3:0]);
        if (m_axis_tdata[35:4] !== want.value)
          flag_mismatch("out_value", want.value, m_axis_tdata[35:4]);
        if (m_axis_tlast !== want.last)
          flag_mismatch("out_last", want.last, m_axis_tlast);
        if (m_axis_tuser !== want.ovf)
          flag_mismatch("out_overflow", want.ovf, m_axis_tuser);
      end
    end
  end

  // Product of two cleared matrices; the index and value fields must be ignored.
  task automatic test_zero_product();
    send_request(mm4_pkg::OP_COMPUTE, 4'hF, 32'hFFFF_FFFF);
  endtask

  // Positive and negative saturation, floor of a tiny negative sum, last index.
  task automatic test_extremes();
    send_request(mm4_pkg::OP_LOAD_LEFT, 4'd0, VAL_MAX);
    send_request(mm4_pkg::OP_LOAD_RIGHT, 4'd0, VAL_MAX);
    send_request(mm4_pkg::OP_LOAD_RIGHT, 4'd4, VAL_MIN);
    send_request(mm4_pkg::OP_LOAD_LEFT, 4'd5, 32'hFFFF_FFFF);
    send_request(mm4_pkg::OP_LOAD_RIGHT, 4'd1, 32'h0000_0001);
    send_request(mm4_pkg::OP_LOAD_LEFT, 4'd15, VAL_MIN);
    send_request(mm4_pkg::OP_LOAD_RIGHT, 4'd15, VAL_MIN);
    send_request(mm4_pkg::OP_LOAD_LEFT, 4'd10, VAL_ONE);
    send_request(mm4_pkg::OP_LOAD_RIGHT, 4'd10, 32'h0000_0000);
    send_request(mm4_pkg::OP_COMPUTE, 4'd0, 32'h0);
  endtask

  // The unused code must neither write a matrix nor emit anything.
  task automatic test_unused_op();
    send_request(OP_UNUSED, 4'd0, 32'h0000_0000);
    send_request(OP_UNUSED, 4'd15, 32'h1234_5678);
    send_request(mm4_pkg::OP_COMPUTE, 4'd7, 32'h5555_AAAA);
  endtask

  task automatic test_random_items(int unsigned count);
    int unsigned pick;
    logic [1:0] op;
    logic [VAL_W-1:0] val;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        src_idle_en  = $urandom_range(0, 1);
        sink_idle_en = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 44) op = mm4_pkg::OP_LOAD_LEFT;
      else if (pick < 88) op = mm4_pkg::OP_LOAD_RIGHT;
      else if (pick < 96) op = mm4_pkg::OP_COMPUTE;
      else op = OP_UNUSED;
      val = $urandom;
      // Half of the values get modest magnitudes so that not every product saturates.
      case ($urandom_range(0, 3))
        0: val = {{12{val[19]}}, val[19:0]};
        1: val = {{8{val[23]}}, val[23:0]};
        default: ;
      endcase
      send_request(op, IDX_W'($urandom_range(0, ELEMS - 1)), val);
    end
  endtask

  // The sink stops for a long stretch while requests keep coming, so the
  // output path fills and the input must stall.
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    sink_hold = 300;
    send_request(mm4_pkg::OP_COMPUTE, 4'd0, 32'h0);
    for (int i = 0; i < 8; i++)
      send_request(mm4_pkg::OP_LOAD_LEFT, IDX_W'($urandom_range(0, ELEMS - 1)), $urandom);
    send_request(mm4_pkg::OP_COMPUTE, 4'd0, 32'h0);
  endtask

  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < ELEMS; i++)
      send_request(mm4_pkg::OP_LOAD_RIGHT, IDX_W'(i), {{14{1'b0}}, 18'($urandom)});
    send_request(mm4_pkg::OP_COMPUTE, 4'd0, 32'h0);
    for (int i = 0; i < 6; i++)
      send_request(mm4_pkg::OP_LOAD_LEFT, IDX_W'($urandom_range(0, ELEMS - 1)), $urandom);
    send_request(mm4_pkg::OP_COMPUTE, 4'd0, 32'h0);
  endtask

  initial begin
    int unsigned waited;
    foreach (lhs_mat[i]) begin
      lhs_mat[i] = '0;
      rhs_mat[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_zero_product();
    test_extremes();
    test_unused_op();
    test_random_items(100);
    test_backpressure();
    test_back_to_back();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_products.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4 * DIM) @(posedge clk_i);
    if (expected_products.size() != 0) begin
      $display("%0d expected products never arrived", expected_products.size());
      mismatches += expected_products.size();
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
